// File: hdl/host_command_framer_translator_macros.svh
// assertion macros for the host command framer translator
`ifndef HOST_COMMAND_FRAMER_TRANSLATOR_MACROS_SVH
`define HOST_COMMAND_FRAMER_TRANSLATOR_MACROS_SVH

// same-cycle implication
`define HCFT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HCFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/hcft_pkg.sv
// shared types, constants and the opcode length table
package hcft_pkg;

    localparam logic [7:0] OPC_LOCO    = 8'hA2;
    localparam logic [7:0] OPC_VERSION = 8'hAA;

    localparam logic [7:0] VER_MAJOR = 8'd7;
    localparam logic [7:0] VER_MINOR = 8'd3;

    localparam logic [2:0] LOCO_LAST_IDX  = 3'd4;
    localparam logic [2:0] REPLY_LAST_IDX = 3'd2;

    localparam logic DEST_BUS  = 1'b0;
    localparam logic DEST_HOST = 1'b1;

    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic            is_reply;
        logic [3:0][7:0] ops;
    } t_cmd;

    function automatic logic [2:0] len_of(input logic [7:0] op);
        logic [2:0] len;
        case (op)
            8'h80, 8'h8C, 8'h9E, 8'h9F, 8'hAA:        len = 3'd1;
            8'h9B, 8'h9C, 8'hA7, 8'hB4, 8'hB5:        len = 3'd2;
            8'hA1, 8'hA6, 8'hA9, 8'hB3:               len = 3'd3;
            8'hA0, 8'hA8:                             len = 3'd4;
            8'hA2, 8'hAD, 8'hB0:                      len = 3'd5;
            8'hAE, 8'hAF:                             len = 3'd6;
            default:                                  len = 3'd0;
        endcase
        return len;
    endfunction

endpackage

// File: hdl/hcft_front.sv
// framer: collects command bytes and queues the commands that produce output
module hcft_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_host_byte,
    output logic          o_push,
    output hcft_pkg::t_cmd o_cmd,
    input  logic          i_full
);
    import hcft_pkg::*;

    logic [7:0]      r_opcode;
    logic [2:0]      r_exp_len;
    logic [2:0]      r_count;
    logic [3:0][7:0] r_ops;

    logic [7:0]      n_opcode;
    logic [2:0]      n_exp_len;
    logic [2:0]      n_count;
    logic [3:0][7:0] n_ops;
    logic            accept;
    logic            done;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_opcode  = r_opcode;
        n_exp_len = r_exp_len;
        n_count   = r_count;
        n_ops     = r_ops;
        if (r_exp_len == 3'd0) begin
            n_opcode  = i_host_byte;
            n_exp_len = len_of(i_host_byte);
            n_count   = 3'd1;
        end else begin
            case (r_count)
                3'd1:    n_ops[0] = i_host_byte;
                3'd2:    n_ops[1] = i_host_byte;
                3'd3:    n_ops[2] = i_host_byte;
                3'd4:    n_ops[3] = i_host_byte;
                default: n_ops    = r_ops;
            endcase
            n_count = r_count + 3'd1;
        end
    end

    assign done         = n_count >= n_exp_len;
    assign o_push       = accept && done && (n_opcode == OPC_LOCO || n_opcode == OPC_VERSION);
    assign o_cmd.is_reply = (n_opcode == OPC_VERSION);
    assign o_cmd.ops    = n_ops;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opcode  <= '0;
            r_exp_len <= '0;
            r_count   <= '0;
        end else if (accept) begin
            r_opcode <= n_opcode;
            if (done) begin
                r_exp_len <= '0;
                r_count   <= '0;
            end else begin
                r_exp_len <= n_exp_len;
                r_count   <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ops <= n_ops;
        end
    end

endmodule

// File: hdl/hcft_queue.sv
// short command queue between framer and emitter
module hcft_queue #(
    parameter int DEPTH = hcft_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hcft_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output hcft_pkg::t_cmd o_cmd
);
    import hcft_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    t_cmd          r_rd_data;
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_rd_data;

    // read data is loaded on pop and held until the next pop
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
        if (do_pop) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: hdl/hcft_back.sv
// emitter: expands queued commands into output bytes through an output register
module hcft_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  hcft_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_out_byte,
    output logic           o_destination,
    output logic           o_last_of_run
);
    import hcft_pkg::*;

    logic       r_busy;
    logic [2:0] r_idx;
    logic       r_ov;
    logic [7:0] r_byte;
    logic       r_dest;
    logic       r_last;

    logic       out_free;
    logic       emit;
    logic       is_last;
    logic [2:0] last_idx;
    logic [11:0] addr;
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] n_byte;

    // i_cmd is the queue's read register, stable from one pop to the next
    assign out_free = !r_ov || i_ready;
    assign emit     = r_busy && out_free;
    assign last_idx = i_cmd.is_reply ? REPLY_LAST_IDX : LOCO_LAST_IDX;
    assign is_last  = (r_idx == last_idx);
    assign o_pop    = !i_empty && (!r_busy || (emit && is_last));

    assign addr = {i_cmd.ops[0][3:0], i_cmd.ops[1]};
    assign c0   = {3'b000, addr[11:7]};
    assign c1   = {1'b0, addr[6:0]};

    always_comb begin
        if (i_cmd.is_reply) begin
            n_byte = (r_idx == 3'd0) ? VER_MAJOR : VER_MINOR;
        end else begin
            case (r_idx)
                3'd0:    n_byte = c0;
                3'd1:    n_byte = c1;
                3'd2:    n_byte = i_cmd.ops[2];
                3'd3:    n_byte = i_cmd.ops[3];
                default: n_byte = c0 ^ c1 ^ i_cmd.ops[2] ^ i_cmd.ops[3];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (emit) begin
                if (is_last) begin
                    r_busy <= 1'b0;
                end
                r_idx <= r_idx + 3'd1;
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte <= n_byte;
            r_dest <= i_cmd.is_reply ? DEST_HOST : DEST_BUS;
            r_last <= is_last;
        end
    end

    assign o_valid       = r_ov;
    assign o_out_byte    = r_byte;
    assign o_destination = r_dest;
    assign o_last_of_run = r_last;

endmodule

// File: hdl/host_command_framer_translator.sv
// host command framer and translator, top level
//
// channel   direction  handshake          payload
// input     in         i_valid / o_ready  i_host_byte
// output    out        o_valid / i_ready  o_out_byte, o_destination, o_last_of_run
//
// one host byte per cycle while the queue has room; a command is queued with its last byte
// output runs one byte per cycle unless stalled: 5 per bus command, 3 per version reply
// the command queue (QUEUE_DEPTH entries) decouples framing from byte emission
// o_ready drops only while the command queue is full
// synchronous active-low reset clears framing state, queue pointers and output valid
module host_command_framer_translator #(
    parameter int QUEUE_DEPTH = hcft_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_host_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_destination,
    output logic       o_last_of_run
);
    import hcft_pkg::*;

    logic push;
    logic full;
    logic pop;
    logic empty;
    t_cmd cmd_in;
    t_cmd cmd_out;

    hcft_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_host_byte (i_host_byte),
        .o_push      (push),
        .o_cmd       (cmd_in),
        .i_full      (full)
    );

    hcft_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (cmd_out)
    );

    hcft_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_cmd         (cmd_out),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_destination (o_destination),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// File: hdl/hcft_checker.sv
// port-level checks for the host command framer translator
`include "host_command_framer_translator_macros.svh"

module hcft_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_out_byte,
    input logic       o_destination,
    input logic       o_last_of_run
);

    `HCFT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_out_byte) && $stable(o_destination) && $stable(o_last_of_run), "output request changed while stalled")

    `HCFT_ASSERT_NOW(a_reply_value, i_clk, i_rst_n, o_valid && o_destination, (o_out_byte == 8'd7 && !o_last_of_run) || o_out_byte == 8'd3, "bad version reply byte")

    `HCFT_ASSERT_NEXT(a_reply_seq, i_clk, i_rst_n, o_valid && i_ready && o_destination && o_out_byte == 8'd7, o_valid && o_destination && o_out_byte == 8'd3 && !o_last_of_run, "version reply sequence broken")

endmodule

bind host_command_framer_translator hcft_checker u_hcft_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_out_byte    (o_out_byte),
    .o_destination (o_destination),
    .o_last_of_run (o_last_of_run)
);

// File: tb/sv/tb_host_command_framer_translator.sv
// testbench for the host command framer translator: self-checking, random idling and stalls
`timescale 1ns / 100ps

module tb_host_command_framer_translator;
    import hcft_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES = 150;

    localparam logic [7:0] OPC_FIRST = 8'h80;
    localparam logic [7:0] OPC_LAST = 8'hB5;
    localparam logic [7:0] OPC_NO_LEN = 8'h81;
    localparam logic [7:0] OPC_LONG = 8'hAE;

    // command length per opcode, opcode included, from OPC_FIRST up
    localparam bit [0:53][2:0] LEN_ROW = {
        3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
        3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd0, 3'd0, 3'd0,
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
        3'd0, 3'd0, 3'd0, 3'd2, 3'd2, 3'd0, 3'd1, 3'd1,
        3'd4, 3'd3, 3'd5, 3'd0, 3'd0, 3'd0, 3'd3, 3'd2,
        3'd4, 3'd3, 3'd1, 3'd0, 3'd0, 3'd5, 3'd6, 3'd6,
        3'd5, 3'd0, 3'd0, 3'd3, 3'd2, 3'd2
    };

    class t_framer_board;
        typedef struct {
            logic [7:0] data;
            logic       dest;
            logic       last;
        } t_out_rec;

        t_out_rec   pending_out[$];
        logic [7:0] cmd_opcode;
        logic [2:0] cmd_len;
        logic [2:0] cmd_count;
        logic [7:0] cmd_operands[4];
        int         mismatches;
        int         requests_seen;
        int         loco_runs;
        int         reply_runs;

        function new();
            cmd_opcode = '0;
            cmd_len = '0;
            cmd_count = '0;
            foreach (cmd_operands[i]) cmd_operands[i] = '0;
            mismatches = 0;
            requests_seen = 0;
            loco_runs = 0;
            reply_runs = 0;
        endfunction

        function logic [2:0] length_of_op(logic [7:0] op);
            if (op < OPC_FIRST || op > OPC_LAST) begin
                return 3'd0;
            end
            return LEN_ROW[op - OPC_FIRST];
        endfunction

        function void push_out(logic [7:0] data, logic dest, logic last);
            t_out_rec rec;
            rec.data = data;
            rec.dest = dest;
            rec.last = last;
            pending_out.push_back(rec);
        endfunction

        function void note_request(logic [7:0] b);
            logic [11:0] addr;
            logic [7:0]  hi;
            logic [7:0]  lo;
            requests_seen++;
            if (cmd_len != 0) begin
                if (cmd_count < cmd_len) begin
                    if (cmd_count >= 1 && cmd_count <= 4) begin
                        cmd_operands[cmd_count - 1] = b;
                    end
                    cmd_count = cmd_count + 3'd1;
                end
            end else begin
                cmd_opcode = b;
                cmd_len = length_of_op(b);
                cmd_count = 3'd1;
            end
            if (cmd_count >= cmd_len) begin
                if (cmd_opcode == OPC_LOCO) begin
                    // top nibble of the first operand drops out of the address
                    addr = {cmd_operands[0][3:0], cmd_operands[1]};
                    hi = {3'b000, addr[11:7]};
                    lo = {1'b0, addr[6:0]};
                    push_out(hi, DEST_BUS, 1'b0);
                    push_out(lo, DEST_BUS, 1'b0);
                    push_out(cmd_operands[2], DEST_BUS, 1'b0);
                    push_out(cmd_operands[3], DEST_BUS, 1'b0);
                    push_out(hi ^ lo ^ cmd_operands[2] ^ cmd_operands[3], DEST_BUS, 1'b1);
                    loco_runs++;
                end else if (cmd_opcode == OPC_VERSION) begin
                    push_out(VER_MAJOR, DEST_HOST, 1'b0);
                    push_out(VER_MINOR, DEST_HOST, 1'b0);
                    push_out(VER_MINOR, DEST_HOST, 1'b1);
                    reply_runs++;
                end
                cmd_len = '0;
                cmd_count = '0;
            end
        endfunction

        function void check_result(logic [7:0] data, logic dest, logic last);
            t_out_rec want;
            if (pending_out.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("[%0t] unexpected output byte %02h dest %0d last %0d",
                             $realtime, data, dest, last);
                end
                return;
            end
            want = pending_out.pop_front();
            if (want.data !== data || want.dest !== dest || want.last !== last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("[%0t] mismatch: expected byte %02h dest %0d last %0d, got %02h %0d %0d",
                             $realtime, want.data, want.dest, want.last, data, dest, last);
                end
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [7:0] i_host_byte = 8'h00;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_destination;
    logic       o_last_of_run;

    t_framer_board board;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    int          hold_ask = 0;
    int          hold_left = 0;
    int          cyc = 0;

    host_command_framer_translator u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_host_byte  (i_host_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_destination(o_destination),
        .o_last_of_run(o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // output side: check accepted bytes, random stalls, long hold-off on request
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            board.check_result(o_out_byte, o_destination, o_last_of_run);
        end
        if (hold_ask != 0) begin
            hold_left = hold_ask;
            hold_ask = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial begin : watchdog
        while (cyc < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cyc++;
        end
        $display("host_command_framer_translator verification failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        i_valid <= 1'b1;
        i_host_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_request(b);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
    endtask

    task automatic send_command(input logic [7:0] op, input int n_operands);
        send_byte(op);
        repeat (n_operands) send_byte(8'($urandom_range(255)));
    endtask

    task automatic send_loco(input logic [7:0] a1, input logic [7:0] a2,
                             input logic [7:0] d1, input logic [7:0] d2);
        send_byte(OPC_LOCO);
        send_byte(a1);
        send_byte(a2);
        send_byte(d1);
        send_byte(d2);
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        while (board.pending_out.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(input int n_bytes);
        int         start;
        int         pick;
        logic [7:0] op;
        start = board.requests_seen;
        while (board.requests_seen - start < n_bytes) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                send_command(OPC_LOCO, 4);
            end else if (pick < 55) begin
                send_byte(OPC_VERSION);
            end else if (pick < 85) begin
                op = OPC_FIRST + 8'($urandom_range(OPC_LAST - OPC_FIRST));
                send_command(op, int'(board.length_of_op(op)) - (board.length_of_op(op) != 0));
            end else begin
                // stray byte, may open a command that the next ones complete
                send_byte(8'($urandom_range(255)));
            end
        end
        wait_drain();
    endtask

    initial begin : main
        board = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, out-of-range and zero-length opcodes, long commands
        send_loco(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_loco(8'h00, 8'h00, 8'h00, 8'h00);
        send_byte(OPC_VERSION);
        send_byte(8'h00);
        send_byte(OPC_FIRST - 8'd1);
        send_byte(OPC_LAST + 8'd1);
        send_byte(8'hFF);
        send_byte(OPC_NO_LEN);
        send_byte(OPC_FIRST);
        send_command(OPC_LONG, 5);
        send_command(OPC_LAST, 1);
        wait_drain();

        tx_idle_pct = 0;
        rx_stall_pct = 0;
        run_random(12);
        tx_idle_pct = 86;
        rx_stall_pct = 0;
        run_random(12);
        tx_idle_pct = 0;
        rx_stall_pct = 86;
        run_random(12);
        tx_idle_pct = 25;
        rx_stall_pct = 25;
        run_random(12);

        // long output hold-off while the input keeps offering commands
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        while (board.cmd_len != 0) send_byte(8'h00);
        hold_ask = HOLD_CYCLES;
        repeat (6) send_command(OPC_LOCO, 4);
        wait_drain();

        $display("run covered %0d host bytes, %0d bus commands, %0d version replies",
                 board.requests_seen, board.loco_runs, board.reply_runs);
        $display("idle mixes: none, sparse input, stalled output, both, long output hold-off");
        if (board.mismatches == 0 && board.pending_out.size() == 0) begin
            $display("host_command_framer_translator verification clean");
        end else begin
            $display("host_command_framer_translator verification failed");
        end
        $finish;
    end

endmodule
